// File: rtl/assert_macros.svh
// assertion macros used by the rtl top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked on every aclk edge outside reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every aclk edge outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/hvps_pkg.sv
// shared types, codes and constants of the hv relay precharge sequencer
package hvps_pkg;

    localparam int TICK_BITS_DEF = 24;
    localparam int VOLT_BITS_DEF = 16;

    localparam int STATE_W    = 3;
    localparam int WAIT_W     = 24;
    localparam int HV_LEVEL_W = 16;
    localparam int RATIO_W    = 9;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam logic [STATE_W-1:0] ST_OFF  = 3'd0;
    localparam logic [STATE_W-1:0] ST_IDLE = 3'd1;
    localparam logic [STATE_W-1:0] ST_PRE  = 3'd2;
    localparam logic [STATE_W-1:0] ST_ON   = 3'd3;
    localparam logic [STATE_W-1:0] ST_ERR  = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_OFF_IDLE_WAIT       = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IDLE_PRECHARGE_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PRECHARGE_MIN_TICKS = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PRECHARGE_TIMEOUT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_HV_LEVEL        = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHARGE_RATIO        = 3'd5;

    localparam logic [WAIT_W-1:0]     RST_OFF_IDLE_WAIT       = 24'd1000;
    localparam logic [WAIT_W-1:0]     RST_IDLE_PRECHARGE_WAIT = 24'd1000;
    localparam logic [WAIT_W-1:0]     RST_PRECHARGE_MIN_TICKS = 24'd500;
    localparam logic [WAIT_W-1:0]     RST_PRECHARGE_TIMEOUT   = 24'd5000;
    localparam logic [HV_LEVEL_W-1:0] RST_MIN_HV_LEVEL        = 16'd600;
    localparam logic [RATIO_W-1:0]    RST_CHARGE_RATIO        = 9'd230;

    typedef struct packed {
        logic [WAIT_W-1:0]     off_idle_wait;
        logic [WAIT_W-1:0]     idle_precharge_wait;
        logic [WAIT_W-1:0]     precharge_min_ticks;
        logic [WAIT_W-1:0]     precharge_timeout;
        logic [HV_LEVEL_W-1:0] min_hv_level;
        logic [RATIO_W-1:0]    charge_ratio;
    } cfg_t;

    typedef struct packed {
        logic [STATE_W-1:0] state_code;
        logic               relay_positive;
        logic               relay_negative;
        logic               relay_precharge;
        logic               error_line;
        logic               precharge_active;
        logic               hv_active;
        logic               request_pending;
    } res_t;

endpackage

// File: rtl/hv_relay_precharge_sequencer.sv
// top level of the hv relay precharge sequencer: handshakes, input and result registers
//
// Each transfer on the s_ channel is one control-timer tick carrying the interlock,
// charger, fault and request flags and the bus and pack voltages. Every tick yields
// exactly one result on the m_ channel: state code, relay drives and status flags.
// The cfg_ channel writes the six timing and threshold registers by index; writes to
// unused indexes are dropped. cfg_ready is always high.
//
// A tick lands in the input register at its transfer edge; the state machine
// evaluates it there, and its result is loaded into the result register when
// that register is free or being drained, raising m_valid. One tick per cycle
// is taken while the receiver keeps m_ready high; the rate is set by the single
// state update per cycle. When the receiver holds m_ready low, the result waits
// in the result register and one further tick can sit in the input register;
// s_ready then drops until the result is taken.
// A synchronous low aresetn empties both registers, puts the machine in off with
// the counter, request latch and flags cleared, and loads the register defaults.
`include "assert_macros.svh"

module hv_relay_precharge_sequencer #(
    parameter int TICK_BITS = hvps_pkg::TICK_BITS_DEF,
    parameter int VOLT_BITS = hvps_pkg::VOLT_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,

    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_interlock_closed,
    input  logic                               s_charger_present,
    input  logic                               s_fault,
    input  logic                               s_hv_request,
    input  logic [VOLT_BITS-1:0]               s_bus_voltage,
    input  logic [VOLT_BITS-1:0]               s_pack_voltage,

    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [hvps_pkg::STATE_W-1:0]       m_state_code,
    output logic                               m_relay_positive,
    output logic                               m_relay_negative,
    output logic                               m_relay_precharge,
    output logic                               m_error_line,
    output logic                               m_precharge_active,
    output logic                               m_hv_active,
    output logic                               m_request_pending,

    input  logic                               cfg_valid,
    output logic                               cfg_ready,
    input  logic [hvps_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [hvps_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic                 in_valid_reg;
    logic                 ilk_reg, chg_reg, flt_reg, req_reg;
    logic [VOLT_BITS-1:0] bus_reg, pack_reg;

    logic                 out_valid_reg;
    hvps_pkg::res_t       res_reg;
    hvps_pkg::res_t       res_next;
    hvps_pkg::cfg_t       cfg;

    logic                 advance;
    logic                 s_xfer;

    // the held tick moves on when the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready   = !in_valid_reg || advance;
    assign s_xfer    = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    hvps_cfg_regs u_cfg (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    hvps_fsm #(
        .TICK_BITS (TICK_BITS),
        .VOLT_BITS (VOLT_BITS)
    ) u_fsm (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .step             (advance),
        .interlock_closed (ilk_reg),
        .charger_present  (chg_reg),
        .fault            (flt_reg),
        .hv_request       (req_reg),
        .bus_voltage      (bus_reg),
        .pack_voltage     (pack_reg),
        .cfg              (cfg),
        .res              (res_next)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_xfer) begin
                in_valid_reg <= 1'b1;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            ilk_reg  <= s_interlock_closed;
            chg_reg  <= s_charger_present;
            flt_reg  <= s_fault;
            req_reg  <= s_hv_request;
            bus_reg  <= s_bus_voltage;
            pack_reg <= s_pack_voltage;
        end
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_state_code       = res_reg.state_code;
    assign m_relay_positive   = res_reg.relay_positive;
    assign m_relay_negative   = res_reg.relay_negative;
    assign m_relay_precharge  = res_reg.relay_precharge;
    assign m_error_line       = res_reg.error_line;
    assign m_precharge_active = res_reg.precharge_active;
    assign m_hv_active        = res_reg.hv_active;
    assign m_request_pending  = res_reg.request_pending;

    `ASSERT_NEXT(a_error_sticky, m_valid && m_error_line, !m_valid || m_error_line, "error dropped")
    `ASSERT_IMPLIES(a_relay_excl, m_valid, !(m_relay_positive && m_relay_precharge), "relay clash")
    `ASSERT_IMPLIES(a_hv_in_on, m_valid && m_hv_active, m_state_code == hvps_pkg::ST_ON, "hv flag")
    `ASSERT_IMPLIES(a_pre_in_pre, m_valid && m_precharge_active, m_relay_precharge, "pre flag")

endmodule

// File: rtl/hvps_cfg_regs.sv
// configuration register file of the sequencer
module hvps_cfg_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               wr_en,
    input  logic [hvps_pkg::CFG_IDX_W-1:0]     wr_index,
    input  logic [hvps_pkg::CFG_DATA_W-1:0]    wr_data,
    output hvps_pkg::cfg_t                     cfg
);

    hvps_pkg::cfg_t cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.off_idle_wait       <= hvps_pkg::RST_OFF_IDLE_WAIT;
            cfg_reg.idle_precharge_wait <= hvps_pkg::RST_IDLE_PRECHARGE_WAIT;
            cfg_reg.precharge_min_ticks <= hvps_pkg::RST_PRECHARGE_MIN_TICKS;
            cfg_reg.precharge_timeout   <= hvps_pkg::RST_PRECHARGE_TIMEOUT;
            cfg_reg.min_hv_level        <= hvps_pkg::RST_MIN_HV_LEVEL;
            cfg_reg.charge_ratio        <= hvps_pkg::RST_CHARGE_RATIO;
        end else if (wr_en) begin
            unique case (wr_index)
                hvps_pkg::REG_OFF_IDLE_WAIT: begin
                    cfg_reg.off_idle_wait <= wr_data[hvps_pkg::WAIT_W-1:0];
                end
                hvps_pkg::REG_IDLE_PRECHARGE_WAIT: begin
                    cfg_reg.idle_precharge_wait <= wr_data[hvps_pkg::WAIT_W-1:0];
                end
                hvps_pkg::REG_PRECHARGE_MIN_TICKS: begin
                    cfg_reg.precharge_min_ticks <= wr_data[hvps_pkg::WAIT_W-1:0];
                end
                hvps_pkg::REG_PRECHARGE_TIMEOUT: begin
                    cfg_reg.precharge_timeout <= wr_data[hvps_pkg::WAIT_W-1:0];
                end
                hvps_pkg::REG_MIN_HV_LEVEL: begin
                    cfg_reg.min_hv_level <= wr_data[hvps_pkg::HV_LEVEL_W-1:0];
                end
                hvps_pkg::REG_CHARGE_RATIO: begin
                    cfg_reg.charge_ratio <= wr_data[hvps_pkg::RATIO_W-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// File: rtl/hvps_fsm.sv
// sequencer state machine: state, tick counter, latch and flags, one tick per step
module hvps_fsm #(
    parameter int TICK_BITS = hvps_pkg::TICK_BITS_DEF,
    parameter int VOLT_BITS = hvps_pkg::VOLT_BITS_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  logic                 interlock_closed,
    input  logic                 charger_present,
    input  logic                 fault,
    input  logic                 hv_request,
    input  logic [VOLT_BITS-1:0] bus_voltage,
    input  logic [VOLT_BITS-1:0] pack_voltage,
    input  hvps_pkg::cfg_t       cfg,
    output hvps_pkg::res_t       res
);

    localparam int CMP_W  = (TICK_BITS > hvps_pkg::WAIT_W) ? TICK_BITS : hvps_pkg::WAIT_W;
    localparam int LVL_W  = (VOLT_BITS > hvps_pkg::HV_LEVEL_W) ? VOLT_BITS
                                                                : hvps_pkg::HV_LEVEL_W;
    localparam int PROD_W = VOLT_BITS + hvps_pkg::RATIO_W;

    logic [hvps_pkg::STATE_W-1:0] state_reg, state_next;
    logic [TICK_BITS-1:0]         ticks_reg, ticks_next;
    logic                         latch_reg, latch_next;
    logic                         err_reg, err_next;
    logic                         pre_flag_reg, pre_flag_next;
    logic                         hv_flag_reg, hv_flag_next;

    logic [TICK_BITS-1:0] ticks_inc;
    logic                 latch_set;
    logic                 discharged;
    logic                 charged;
    logic                 t_gt_off, t_gt_idle, t_gt_min, t_gt_max;
    logic [PROD_W-1:0]    bus_scaled, pack_scaled;

    // counter saturates at all ones
    assign ticks_inc  = (&ticks_reg) ? ticks_reg : ticks_reg + TICK_BITS'(1);
    assign latch_set  = latch_reg | hv_request;
    assign discharged = LVL_W'(bus_voltage) <= LVL_W'(cfg.min_hv_level);

    assign bus_scaled  = PROD_W'(bus_voltage) << 8;
    assign pack_scaled = PROD_W'(pack_voltage) * PROD_W'(cfg.charge_ratio);
    assign charged     = bus_scaled >= pack_scaled;

    assign t_gt_off  = CMP_W'(ticks_inc) > CMP_W'(cfg.off_idle_wait);
    assign t_gt_idle = CMP_W'(ticks_inc) > CMP_W'(cfg.idle_precharge_wait);
    assign t_gt_min  = CMP_W'(ticks_inc) > CMP_W'(cfg.precharge_min_ticks);
    assign t_gt_max  = CMP_W'(ticks_inc) > CMP_W'(cfg.precharge_timeout);

    always_comb begin
        state_next    = state_reg;
        latch_next    = latch_set;
        err_next      = err_reg;
        pre_flag_next = pre_flag_reg;
        hv_flag_next  = hv_flag_reg;
        ticks_next    = ticks_inc;

        // first matching edge wins
        unique case (state_reg)
            hvps_pkg::ST_OFF: begin
                if (!charger_present && t_gt_off) begin
                    state_next = hvps_pkg::ST_IDLE;
                end
            end
            hvps_pkg::ST_IDLE: begin
                priority if (charger_present) begin
                    state_next = hvps_pkg::ST_OFF;
                end else if (discharged && interlock_closed && latch_set && t_gt_idle) begin
                    state_next = hvps_pkg::ST_PRE;
                end else if (fault) begin
                    state_next = hvps_pkg::ST_ERR;
                end else begin
                    state_next = state_reg;
                end
            end
            hvps_pkg::ST_PRE: begin
                priority if (t_gt_min && charged) begin
                    state_next = hvps_pkg::ST_ON;
                end else if ((latch_set && t_gt_idle) || !interlock_closed) begin
                    state_next = hvps_pkg::ST_IDLE;
                end else if ((discharged && t_gt_min) || t_gt_max || fault) begin
                    state_next = hvps_pkg::ST_ERR;
                end else begin
                    state_next = state_reg;
                end
            end
            hvps_pkg::ST_ON: begin
                priority if (!interlock_closed) begin
                    state_next = hvps_pkg::ST_IDLE;
                end else if (fault) begin
                    state_next = hvps_pkg::ST_ERR;
                end else begin
                    state_next = state_reg;
                end
            end
            default: begin
            end
        endcase

        if (state_next != state_reg) begin
            ticks_next = '0;
            // exit action of the old state
            unique case (state_reg)
                hvps_pkg::ST_IDLE: begin
                    latch_next = 1'b0;
                end
                hvps_pkg::ST_PRE: begin
                    pre_flag_next = 1'b0;
                    latch_next    = 1'b0;
                end
                hvps_pkg::ST_ON: begin
                    hv_flag_next = 1'b0;
                    latch_next   = 1'b0;
                end
                default: begin
                end
            endcase
            // entry action of the new state
            unique case (state_next)
                hvps_pkg::ST_OFF: begin
                    latch_next    = 1'b0;
                    pre_flag_next = 1'b0;
                    hv_flag_next  = 1'b0;
                end
                hvps_pkg::ST_PRE: begin
                    pre_flag_next = 1'b1;
                end
                hvps_pkg::ST_ON: begin
                    hv_flag_next = 1'b1;
                end
                hvps_pkg::ST_ERR: begin
                    err_next = 1'b1;
                end
                default: begin
                end
            endcase
        end else begin
            unique case (state_reg)
                hvps_pkg::ST_OFF: begin
                    latch_next    = 1'b0;
                    pre_flag_next = 1'b0;
                    hv_flag_next  = 1'b0;
                end
                hvps_pkg::ST_IDLE: begin
                    if (!interlock_closed) begin
                        latch_next = 1'b0;
                    end
                end
                hvps_pkg::ST_ERR: begin
                    pre_flag_next = 1'b0;
                    latch_next    = 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= hvps_pkg::ST_OFF;
            ticks_reg    <= '0;
            latch_reg    <= 1'b0;
            err_reg      <= 1'b0;
            pre_flag_reg <= 1'b0;
            hv_flag_reg  <= 1'b0;
        end else if (step) begin
            state_reg    <= state_next;
            ticks_reg    <= ticks_next;
            latch_reg    <= latch_next;
            err_reg      <= err_next;
            pre_flag_reg <= pre_flag_next;
            hv_flag_reg  <= hv_flag_next;
        end
    end

    always_comb begin
        res.state_code       = state_next;
        res.relay_positive   = state_next == hvps_pkg::ST_ON;
        res.relay_negative   = (state_next == hvps_pkg::ST_ON) ||
                               (state_next == hvps_pkg::ST_PRE);
        res.relay_precharge  = state_next == hvps_pkg::ST_PRE;
        res.error_line       = err_next;
        res.precharge_active = pre_flag_next;
        res.hv_active        = hv_flag_next;
        res.request_pending  = latch_next;
    end

endmodule

// File: test/tb.sv
// testbench for hv_relay_precharge_sequencer: tick stimulus, status prediction and checks
`timescale 1ns / 100ps

module tb;

    localparam int VOLT_W        = hvps_pkg::VOLT_BITS_DEF;
    localparam int SETTLE_CYCLES = 4;
    localparam int STALL_LIMIT   = 1000;
    localparam int HOLD_CYCLES   = 64;
    localparam int WALK_PHASES   = 5;
    localparam int WALK_ITEMS    = 70;

    // indexes with no register behind them
    localparam logic [hvps_pkg::CFG_IDX_W-1:0] REG_UNUSED_LO = 3'd6;
    localparam logic [hvps_pkg::CFG_IDX_W-1:0] REG_UNUSED_HI = 3'd7;

    typedef struct packed {
        logic              interlock;
        logic              charger;
        logic              fault;
        logic              request;
        logic [VOLT_W-1:0] car;
        logic [VOLT_W-1:0] pack;
    } tick_t;

    typedef struct packed {
        logic [hvps_pkg::STATE_W-1:0] mode;
        logic [hvps_pkg::WAIT_W-1:0]  ticks;
        logic                         req_latch;
        logic                         err_sticky;
        logic                         pre_flag;
        logic                         hv_flag;
    } relay_seq_t;

    logic aclk    = 1'b0;
    logic aresetn = 1'b0;

    logic              s_valid            = 1'b0;
    logic              s_ready;
    logic              s_interlock_closed = 1'b0;
    logic              s_charger_present  = 1'b0;
    logic              s_fault            = 1'b0;
    logic              s_hv_request       = 1'b0;
    logic [VOLT_W-1:0] s_bus_voltage      = '0;
    logic [VOLT_W-1:0] s_pack_voltage     = '0;

    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic [hvps_pkg::STATE_W-1:0] m_state_code;
    logic                         m_relay_positive;
    logic                         m_relay_negative;
    logic                         m_relay_precharge;
    logic                         m_error_line;
    logic                         m_precharge_active;
    logic                         m_hv_active;
    logic                         m_request_pending;

    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic [hvps_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
    logic [hvps_pkg::CFG_DATA_W-1:0] cfg_data  = '0;

    hvps_pkg::cfg_t regs;
    relay_seq_t     relay_seq;
    hvps_pkg::res_t pending_status[$];
    int             mismatches   = 0;
    int             quiet_cycles = 0;
    bit             tx_eager     = 1'b0;
    bit             rx_eager     = 1'b0;
    bit             hold_results = 1'b0;

    hv_relay_precharge_sequencer DUT (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_interlock_closed (s_interlock_closed),
        .s_charger_present  (s_charger_present),
        .s_fault            (s_fault),
        .s_hv_request       (s_hv_request),
        .s_bus_voltage      (s_bus_voltage),
        .s_pack_voltage     (s_pack_voltage),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_state_code       (m_state_code),
        .m_relay_positive   (m_relay_positive),
        .m_relay_negative   (m_relay_negative),
        .m_relay_precharge  (m_relay_precharge),
        .m_error_line       (m_error_line),
        .m_precharge_active (m_precharge_active),
        .m_hv_active        (m_hv_active),
        .m_request_pending  (m_request_pending),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // one control tick of the sequencer: edges in priority order, then exit/entry or update
    function automatic relay_seq_t advance_tick(relay_seq_t s, tick_t tk);
        logic [hvps_pkg::STATE_W-1:0] nxt;
        logic                         low_bus;
        logic                         ratio_met;
        logic [31:0]                  car_scaled;
        logic [31:0]                  pack_scaled;
        if (tk.request)
            s.req_latch = 1'b1;
        if (s.ticks != '1)
            s.ticks = s.ticks + hvps_pkg::WAIT_W'(1);
        low_bus     = tk.car <= regs.min_hv_level;
        car_scaled  = {8'd0, tk.car, 8'd0};
        pack_scaled = 32'(tk.pack) * 32'(regs.charge_ratio);
        ratio_met   = car_scaled >= pack_scaled;
        nxt = s.mode;
        case (s.mode)
            hvps_pkg::ST_OFF: begin
                if (!tk.charger && s.ticks > regs.off_idle_wait)
                    nxt = hvps_pkg::ST_IDLE;
            end
            hvps_pkg::ST_IDLE: begin
                if (tk.charger)
                    nxt = hvps_pkg::ST_OFF;
                else if (low_bus && tk.interlock && s.req_latch &&
                         s.ticks > regs.idle_precharge_wait)
                    nxt = hvps_pkg::ST_PRE;
                else if (tk.fault)
                    nxt = hvps_pkg::ST_ERR;
            end
            hvps_pkg::ST_PRE: begin
                if (s.ticks > regs.precharge_min_ticks && ratio_met)
                    nxt = hvps_pkg::ST_ON;
                else if ((s.req_latch && s.ticks > regs.idle_precharge_wait) ||
                         !tk.interlock)
                    nxt = hvps_pkg::ST_IDLE;
                else if ((low_bus && s.ticks > regs.precharge_min_ticks) ||
                         s.ticks > regs.precharge_timeout || tk.fault)
                    nxt = hvps_pkg::ST_ERR;
            end
            hvps_pkg::ST_ON: begin
                if (!tk.interlock)
                    nxt = hvps_pkg::ST_IDLE;
                else if (tk.fault)
                    nxt = hvps_pkg::ST_ERR;
            end
            default: ;
        endcase
        if (nxt != s.mode) begin
            case (s.mode)
                hvps_pkg::ST_IDLE: s.req_latch = 1'b0;
                hvps_pkg::ST_PRE: begin
                    s.pre_flag  = 1'b0;
                    s.req_latch = 1'b0;
                end
                hvps_pkg::ST_ON: begin
                    s.hv_flag   = 1'b0;
                    s.req_latch = 1'b0;
                end
                default: ;
            endcase
            case (nxt)
                hvps_pkg::ST_OFF: begin
                    s.req_latch = 1'b0;
                    s.pre_flag  = 1'b0;
                    s.hv_flag   = 1'b0;
                end
                hvps_pkg::ST_PRE: s.pre_flag = 1'b1;
                hvps_pkg::ST_ON: s.hv_flag = 1'b1;
                hvps_pkg::ST_ERR: s.err_sticky = 1'b1;
                default: ;
            endcase
            s.mode  = nxt;
            s.ticks = '0;
        end else begin
            case (s.mode)
                hvps_pkg::ST_OFF: begin
                    s.req_latch = 1'b0;
                    s.pre_flag  = 1'b0;
                    s.hv_flag   = 1'b0;
                end
                hvps_pkg::ST_IDLE: begin
                    if (!tk.interlock)
                        s.req_latch = 1'b0;
                end
                hvps_pkg::ST_ERR: begin
                    s.pre_flag  = 1'b0;
                    s.req_latch = 1'b0;
                end
                default: ;
            endcase
        end
        return s;
    endfunction

    function automatic hvps_pkg::res_t status_of(relay_seq_t s);
        hvps_pkg::res_t r;
        r.state_code       = s.mode;
        r.relay_positive   = s.mode == hvps_pkg::ST_ON;
        r.relay_negative   = s.mode == hvps_pkg::ST_ON || s.mode == hvps_pkg::ST_PRE;
        r.relay_precharge  = s.mode == hvps_pkg::ST_PRE;
        r.error_line       = s.err_sticky;
        r.precharge_active = s.pre_flag;
        r.hv_active        = s.hv_flag;
        r.request_pending  = s.req_latch;
        return r;
    endfunction

    function automatic tick_t tick_of(logic ilk, logic chg, logic flt, logic req,
                                      logic [VOLT_W-1:0] car, logic [VOLT_W-1:0] pack);
        tick_t tk;
        tk.interlock = ilk;
        tk.charger   = chg;
        tk.fault     = flt;
        tk.request   = req;
        tk.car       = car;
        tk.pack      = pack;
        return tk;
    endfunction

    function automatic hvps_pkg::cfg_t settings_of(logic [hvps_pkg::WAIT_W-1:0] off_idle,
                                                   logic [hvps_pkg::WAIT_W-1:0] idle_pre,
                                                   logic [hvps_pkg::WAIT_W-1:0] min_pre,
                                                   logic [hvps_pkg::WAIT_W-1:0] max_pre,
                                                   logic [hvps_pkg::HV_LEVEL_W-1:0] level,
                                                   logic [hvps_pkg::RATIO_W-1:0] ratio);
        hvps_pkg::cfg_t c;
        c.off_idle_wait       = off_idle;
        c.idle_precharge_wait = idle_pre;
        c.precharge_min_ticks = min_pre;
        c.precharge_timeout   = max_pre;
        c.min_hv_level        = level;
        c.charge_ratio        = ratio;
        return c;
    endfunction

    // short waits so the walk gets through every state; level and ratio often at extremes
    function automatic hvps_pkg::cfg_t random_settings();
        logic [hvps_pkg::WAIT_W-1:0]     min_pre;
        logic [hvps_pkg::HV_LEVEL_W-1:0] level;
        logic [hvps_pkg::RATIO_W-1:0]    ratio;
        min_pre = hvps_pkg::WAIT_W'($urandom_range(0, 3));
        case ($urandom_range(0, 3))
            0: level = '0;
            1: level = '1;
            2: level = 16'd600;
            default: level = hvps_pkg::HV_LEVEL_W'($urandom);
        endcase
        case ($urandom_range(0, 4))
            0: ratio = '0;
            1: ratio = 9'd256;
            2: ratio = '1;
            3: ratio = hvps_pkg::RATIO_W'($urandom_range(257, 510));
            default: ratio = hvps_pkg::RATIO_W'($urandom);
        endcase
        return settings_of(hvps_pkg::WAIT_W'($urandom_range(0, 4)),
                           hvps_pkg::WAIT_W'($urandom_range(0, 4)), min_pre,
                           min_pre + hvps_pkg::WAIT_W'($urandom_range(0, 8)), level, ratio);
    endfunction

    // mostly ticks that push the sequencer along, the rest raw noise; unless faults are
    // allowed, ticks that would latch the error state are redrawn or defused
    function automatic tick_t pick_tick(bit allow_fault);
        tick_t       tk;
        relay_seq_t  probe;
        int          tries;
        int unsigned need;
        tries = 0;
        do begin
            tk = tick_t'({$urandom, $urandom});
            if ($urandom_range(0, 4) != 0) begin
                tk.interlock = $urandom_range(0, 9) != 0;
                tk.charger   = $urandom_range(0, 15) == 0;
                tk.fault     = $urandom_range(0, 7) == 0;
                tk.request   = $urandom_range(0, 2) == 0;
                case (relay_seq.mode)
                    hvps_pkg::ST_IDLE: begin
                        if ($urandom_range(0, 3) != 0)
                            tk.car = VOLT_W'($urandom_range(0, 32'(regs.min_hv_level)));
                    end
                    hvps_pkg::ST_PRE: begin
                        tk.interlock = $urandom_range(0, 19) != 0;
                        tk.request   = $urandom_range(0, 7) == 0;
                        if ($urandom_range(0, 1) != 0) begin
                            need = 32'(tk.pack);
                            need = (need * 32'(regs.charge_ratio) + 255) / 256 +
                                   $urandom_range(0, 2);
                            if (need <= 32'hFFFF)
                                tk.car = VOLT_W'(need);
                        end
                    end
                    hvps_pkg::ST_ON: tk.interlock = $urandom_range(0, 7) != 0;
                    default: ;
                endcase
            end
            probe = advance_tick(relay_seq, tk);
            tries++;
        end while (!allow_fault && probe.mode == hvps_pkg::ST_ERR && tries < 8);
        if (!allow_fault && probe.mode == hvps_pkg::ST_ERR) begin
            tk.fault     = 1'b0;
            tk.interlock = 1'b0;
        end
        return tk;
    endfunction

    task automatic send_tick(input tick_t tk);
        int gap;
        gap = tx_eager ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_interlock_closed <= tk.interlock;
        s_charger_present  <= tk.charger;
        s_fault            <= tk.fault;
        s_hv_request       <= tk.request;
        s_bus_voltage      <= tk.car;
        s_pack_voltage     <= tk.pack;
        do @(posedge aclk); while (s_ready !== 1'b1);
        relay_seq = advance_tick(relay_seq, tk);
        pending_status.push_back(status_of(relay_seq));
    endtask

    task automatic send_picked(input int count, input bit allow_fault);
        repeat (count) send_tick(pick_tick(allow_fault));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_status.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [hvps_pkg::CFG_IDX_W-1:0] idx,
                             input logic [hvps_pkg::CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (cfg_ready !== 1'b1);
        case (idx)
            hvps_pkg::REG_OFF_IDLE_WAIT:       regs.off_idle_wait       = data;
            hvps_pkg::REG_IDLE_PRECHARGE_WAIT: regs.idle_precharge_wait = data;
            hvps_pkg::REG_PRECHARGE_MIN_TICKS: regs.precharge_min_ticks = data;
            hvps_pkg::REG_PRECHARGE_TIMEOUT:   regs.precharge_timeout   = data;
            hvps_pkg::REG_MIN_HV_LEVEL:
                regs.min_hv_level = data[hvps_pkg::HV_LEVEL_W-1:0];
            hvps_pkg::REG_CHARGE_RATIO:
                regs.charge_ratio = data[hvps_pkg::RATIO_W-1:0];
            default: ;
        endcase
    endtask

    // upper data bits above a narrow register carry junk; unused indexes go last
    task automatic apply_settings(input hvps_pkg::cfg_t want);
        logic [hvps_pkg::CFG_DATA_W-1:0] junk;
        junk = hvps_pkg::CFG_DATA_W'($urandom);
        write_reg(hvps_pkg::REG_OFF_IDLE_WAIT, want.off_idle_wait);
        write_reg(hvps_pkg::REG_IDLE_PRECHARGE_WAIT, want.idle_precharge_wait);
        write_reg(hvps_pkg::REG_PRECHARGE_MIN_TICKS, want.precharge_min_ticks);
        write_reg(hvps_pkg::REG_PRECHARGE_TIMEOUT, want.precharge_timeout);
        write_reg(hvps_pkg::REG_MIN_HV_LEVEL, {junk[7:0], want.min_hv_level});
        write_reg(hvps_pkg::REG_CHARGE_RATIO,
                  {junk[hvps_pkg::CFG_DATA_W-1:hvps_pkg::RATIO_W], want.charge_ratio});
        write_reg(REG_UNUSED_LO, hvps_pkg::CFG_DATA_W'($urandom));
        write_reg(REG_UNUSED_HI, hvps_pkg::CFG_DATA_W'($urandom));
        cfg_valid <= 1'b0;
    endtask

    task automatic test_field_extremes();
        send_tick(tick_of(1'b1, 1'b1, 1'b1, 1'b1, '1, '1));
        send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b0, '0, '0));
        send_tick(tick_of(1'b1, 1'b0, 1'b1, 1'b0, '0, '1));
        send_tick(tick_of(1'b0, 1'b1, 1'b0, 1'b1, '1, '0));
        drain_results();
    endtask

    task automatic test_directed_walk();
        apply_settings(settings_of(24'd0, 24'd0, 24'd1, 24'd20, 16'd600, 9'd128));
        // charger holds off
        send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b0, 16'd700, 16'd1000));
        // off to idle
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 16'd700, 16'd1000));
        // charger back to off
        send_tick(tick_of(1'b1, 1'b1, 1'b0, 1'b1, 16'd0, 16'd1000));
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 16'd700, 16'd1000));
        // open interlock drops request
        send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b1, 16'd100, 16'd1000));
        // bus not discharged
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b1, 16'd700, 16'd1000));
        // level boundary, to precharge
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 16'd600, 16'd1000));
        // minimum time not yet over
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 16'd99, 16'd200));
        // ratio just short
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 16'd700, 16'd1600));
        // ratio met exactly
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 16'd800, 16'd1600));
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b1, 16'd0, 16'd0));
        // on back to idle
        send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b0, 16'd0, 16'd0));
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b1, 16'd0, '1));
        // interlock abort
        send_tick(tick_of(1'b0, 1'b0, 1'b0, 1'b0, '1, 16'd0));
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b1, 16'd0, 16'd0));
        // request abort
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b1, 16'd700, '1));
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b1, 16'd0, 16'd0));
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, 16'd700, '1));
        send_tick(tick_of(1'b1, 1'b0, 1'b0, 1'b0, '1, '1));
        // open interlock beats fault
        send_tick(tick_of(1'b0, 1'b0, 1'b1, 1'b0, 16'd0, 16'd0));
        drain_results();
    endtask

    task automatic test_saturated_waits();
        apply_settings(settings_of('1, '1, '1, '1, '1, '1));
        send_picked(20, 1'b0);
        drain_results();
    endtask

    task automatic test_random_walk();
        for (int phase = 0; phase < WALK_PHASES; phase++) begin
            apply_settings(random_settings());
            tx_eager = $urandom_range(0, 3) == 0;
            rx_eager = $urandom_range(0, 3) == 0;
            send_picked(WALK_ITEMS, 1'b0);
            drain_results();
        end
    endtask

    task automatic test_backpressure();
        apply_settings(random_settings());
        tx_eager     = 1'b1;
        rx_eager     = 1'b0;
        hold_results = 1'b1;
        send_picked(30, 1'b0);
        drain_results();
        tx_eager = 1'b0;
    endtask

    // error has no exit, so faults are let through only at the very end
    task automatic test_fault_noise();
        apply_settings(random_settings());
        send_picked(40, 1'b1);
        drain_results();
    endtask

    initial begin
        regs = settings_of(hvps_pkg::RST_OFF_IDLE_WAIT, hvps_pkg::RST_IDLE_PRECHARGE_WAIT,
                           hvps_pkg::RST_PRECHARGE_MIN_TICKS, hvps_pkg::RST_PRECHARGE_TIMEOUT,
                           hvps_pkg::RST_MIN_HV_LEVEL, hvps_pkg::RST_CHARGE_RATIO);
        relay_seq = '0;
        relay_seq.mode = hvps_pkg::ST_OFF;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        test_field_extremes();
        test_directed_walk();
        test_saturated_waits();
        test_random_walk();
        test_backpressure();
        test_fault_noise();
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // result side: random stalls per transfer, one long hold-off on request
    initial begin
        int stall;
        wait (aresetn === 1'b1);
        forever begin
            stall = rx_eager ? 0 : $urandom_range(0, 3);
            if (hold_results) begin
                stall        = HOLD_CYCLES;
                hold_results = 1'b0;
            end
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (m_valid !== 1'b1);
        end
    end

    function automatic void check_field(string name, logic [hvps_pkg::STATE_W-1:0] want,
                                        logic [hvps_pkg::STATE_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin : status_check
        hvps_pkg::res_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_status.size() == 0) begin
                $display("%0t: status transfer with none expected, expected nothing, actual %0d",
                         $time, m_state_code);
                mismatches++;
            end else begin
                want = pending_status.pop_front();
                check_field("state_code", want.state_code, m_state_code);
                check_field("relay_positive", want.relay_positive, m_relay_positive);
                check_field("relay_negative", want.relay_negative, m_relay_negative);
                check_field("relay_precharge", want.relay_precharge, m_relay_precharge);
                check_field("error_line", want.error_line, m_error_line);
                check_field("precharge_active", want.precharge_active, m_precharge_active);
                check_field("hv_active", want.hv_active, m_hv_active);
                check_field("request_pending", want.request_pending, m_request_pending);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready === 1'b1) || (m_valid === 1'b1 && m_ready) ||
            (cfg_valid && cfg_ready === 1'b1)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
